>>> hdl/fixed_block_pool_allocator_defines.svh
// Assertion macros used by the checker file of the block pool allocator.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fbpa: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fbpa: next-cycle check failed");

`endif

>>> hdl/fbpa_pkg.sv
// Shared widths, codes and defaults of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned PoolDepthDefault = 1024;

  localparam int unsigned CountW   = 11;
  localparam int unsigned SizeW    = 17;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned OffW     = 26;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 17;

  localparam logic [SizeW-1:0] BlockSizeMin = SizeW'(8);

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty   = 2'd1;
  localparam logic [StatusW-1:0] StatusIgnored = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgBlockCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockSize  = 1'b1;

endpackage

>>> hdl/fbpa_if.sv
// Request and response channel interfaces of the fixed block pool allocator.
interface fbpa_req_if import fbpa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [IdxW-1:0] free_index;

  modport source (output valid, req_type, free_index, input ready);
  modport sink   (input valid, req_type, free_index, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdxW-1:0]    block_index;
  logic [OffW-1:0]    block_offset;
  logic [CountW-1:0]  free_blocks;
  logic               all_free;

  modport source (output valid, status, block_index, block_offset, free_blocks, all_free,
                  input ready);
  modport sink   (input valid, status, block_index, block_offset, free_blocks, all_free,
                  output ready);
endinterface

>>> hdl/fbpa_link_mem.sv
// Link store: one-write, one-read synchronous memory with registered read data.
module fbpa_link_mem import fbpa_pkg::*; #(
  parameter  int unsigned PoolDepth = PoolDepthDefault,
  localparam int unsigned AddrW     = $clog2(PoolDepth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [CountW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [CountW-1:0] rdata_o
);

  logic [CountW-1:0] link_q [PoolDepth];
  logic [CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      link_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= link_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/fbpa_ctrl.sv
// Pool controller: configuration, list head, counters and response register.
module fbpa_ctrl import fbpa_pkg::*; #(
  parameter  int unsigned PoolDepth = PoolDepthDefault,
  localparam int unsigned AddrW     = $clog2(PoolDepth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fbpa_req_if.sink            req_i,
  fbpa_rsp_if.source          rsp_o,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [CountW-1:0]   mem_wdata_o,
  output logic                mem_re_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [CountW-1:0]   mem_rdata_i
);

  localparam logic [31:0]       Depth32    = 32'(PoolDepth);
  localparam logic [CountW-1:0] CountReset = (PoolDepth < 1024) ? CountW'(PoolDepth)
                                                                : CountW'(1024);
  localparam logic [CountW-1:0] CountMax   = CountW'(PoolDepth);
  localparam int unsigned       ProdW      = CountW + SizeW;

  typedef enum logic {StIdle, StResp} state_e;

  state_e            state_q;
  logic [CountW-1:0] count_q, touched_q, free_q, head_q;
  logic [SizeW-1:0]  size_q;
  logic              head_valid_q, out_valid_q;
  logic              ok_q, in_range_q, fwd_q;
  logic [CountW-1:0] fwd_data_q, blk_q;
  logic [ProdW-1:0]  prod_q;
  logic [StatusW-1:0] status_q;
  logic [IdxW-1:0]   index_q;
  logic [OffW-1:0]   offset_q;
  logic [CountW-1:0] free_blocks_q;
  logic              all_free_q;

  logic              req_fire, is_free, lazy_we, alloc_ok, free_ok, free_we;
  logic              out_valid_d;
  logic [31:0]       head_ext, touched_ext, fidx_ext;
  logic [CountW-1:0] fidx, free_inc, link_val, cnt_in;
  logic [SizeW-1:0]  size_in;

  assign req_i.ready = (state_q == StIdle) && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_free     = req_i.req_type;
  assign fidx        = CountW'(req_i.free_index);
  assign head_ext    = 32'(head_q);
  assign touched_ext = 32'(touched_q);
  assign fidx_ext    = 32'(req_i.free_index);
  assign free_inc    = free_q + CountW'(1);

  assign lazy_we  = req_fire && !is_free && (touched_q < count_q) && (touched_ext < Depth32);
  assign alloc_ok = head_valid_q && (free_q != '0);
  assign free_ok  = (free_q < count_q) && (fidx < count_q);
  assign free_we  = req_fire && is_free && free_ok;

  assign mem_we_o    = lazy_we || free_we;
  assign mem_waddr_o = free_we ? fidx_ext[AddrW-1:0] : touched_ext[AddrW-1:0];
  assign mem_wdata_o = free_we ? (head_valid_q ? head_q : count_q)
                               : touched_q + CountW'(1);
  assign mem_re_o    = req_fire && !is_free;
  assign mem_raddr_o = head_ext[AddrW-1:0];

  // A link just written by the lazy step is forwarded past the read port.
  assign link_val = !in_range_q ? '0 : (fwd_q ? fwd_data_q : mem_rdata_i);

  // Drop a taken response beat; raise one for a free or a finished allocate.
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if ((state_q == StResp) || (req_fire && is_free)) begin
      out_valid_d = 1'b1;
    end
  end

  // Clamp configuration values into their legal ranges.
  always_comb begin
    cnt_in = cfg_data_i[CountW-1:0];
    if (cnt_in == '0) begin
      cnt_in = CountW'(1);
    end else if (32'(cnt_in) > Depth32) begin
      cnt_in = CountMax;
    end
    size_in = (cfg_data_i[SizeW-1:0] < BlockSizeMin) ? BlockSizeMin : cfg_data_i[SizeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= CountReset;
      size_q       <= BlockSizeMin;
      head_q       <= '0;
      head_valid_q <= 1'b1;
      free_q       <= CountReset;
      touched_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        StIdle: begin
          if (req_fire) begin
            if (is_free) begin
              if (free_ok) begin
                head_q       <= fidx;
                head_valid_q <= 1'b1;
                free_q       <= free_inc;
              end
            end else begin
              state_q <= StResp;
              if (lazy_we) begin
                touched_q <= touched_q + CountW'(1);
              end
              if (alloc_ok) begin
                free_q <= free_q - CountW'(1);
              end
            end
          end
        end
        StResp: begin
          state_q <= StIdle;
          if (ok_q) begin
            if (free_q != '0) begin
              head_q <= link_val;
            end else begin
              head_valid_q <= 1'b0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBlockCount: begin
            count_q      <= cnt_in;
            free_q       <= cnt_in;
            head_q       <= '0;
            head_valid_q <= 1'b1;
            touched_q    <= '0;
          end
          CfgBlockSize: size_q <= size_in;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: allocate context and response fields.
  always_ff @(posedge clk_i) begin
    if (req_fire && !is_free) begin
      ok_q       <= alloc_ok;
      blk_q      <= head_q;
      in_range_q <= head_ext < Depth32;
      fwd_q      <= lazy_we && (touched_q == head_q);
      fwd_data_q <= touched_q + CountW'(1);
      prod_q     <= {{SizeW{1'b0}}, head_q} * {{CountW{1'b0}}, size_q};
    end
    if (state_q == StIdle && req_fire && is_free) begin
      status_q      <= free_ok ? StatusOk : StatusIgnored;
      index_q       <= '0;
      offset_q      <= '0;
      free_blocks_q <= free_ok ? free_inc : free_q;
      all_free_q    <= free_ok && (free_inc == count_q);
    end else if (state_q == StResp) begin
      status_q      <= ok_q ? StatusOk : StatusEmpty;
      index_q       <= ok_q ? blk_q[IdxW-1:0] : '0;
      offset_q      <= ok_q ? prod_q[OffW-1:0] : '0;
      free_blocks_q <= free_q;
      all_free_q    <= 1'b0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.block_index  = index_q;
  assign rsp_o.block_offset = offset_q;
  assign rsp_o.free_blocks  = free_blocks_q;
  assign rsp_o.all_free     = all_free_q;

endmodule

>>> hdl/fixed_block_pool_allocator.sv
// Fixed block pool allocator: a lazily built free list held in a link memory.
// Responses: a free beat shows its response in the cycle after acceptance; an allocate first
// passes through the StResp state. One free per cycle while the response is taken; an allocate
// blocks new beats until StResp ends, as it waits on the registered read of the head's link.
// Reset: asynchronous, active low; clears head, counters and configuration to defaults.
// The link memory is not cleared; the lazy linking step writes each entry before use.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int unsigned PoolDepth = PoolDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fbpa_req_if.sink            req_i,
  fbpa_rsp_if.source          rsp_o
);

  localparam int unsigned AddrW = $clog2(PoolDepth);

  // Link memory port between controller and store.
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [CountW-1:0] mem_wdata, mem_rdata;

  // Controller: accept beats, run the lazy link and head update, hold the response.
  fbpa_ctrl #(
    .PoolDepth (PoolDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Link store: entry i holds the block that follows block i on the free list.
  fbpa_link_mem #(
    .PoolDepth (PoolDepth)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> hdl/fbpa_checker.sv
// Port-level checker of the fixed block pool allocator and its bind.
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_checker import fbpa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               req_type_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [StatusW-1:0] rsp_status_i,
  input logic [IdxW-1:0]    rsp_block_index_i,
  input logic [OffW-1:0]    rsp_block_offset_i,
  input logic [CountW-1:0]  rsp_free_blocks_i,
  input logic               rsp_all_free_i
);

  // Hold a stalled response beat.
  `FBPA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_block_index_i) && $stable(rsp_block_offset_i) && $stable(rsp_free_blocks_i) && $stable(rsp_all_free_i))

  // An allocate beat occupies the link read: no new beat in the next cycle.
  `FBPA_ASSERT_NXT(a_alloc_busy, clk_i, rst_ni, req_valid_i && req_ready_i && !req_type_i, !req_ready_i)

  // Only an ok allocate carries an index and offset; only an ok beat can raise all_free.
  `FBPA_ASSERT_IMP(a_zero_fields, clk_i, rst_ni, rsp_valid_i && rsp_status_i != StatusOk, rsp_block_index_i == '0 && rsp_block_offset_i == '0 && !rsp_all_free_i)

  // An empty pool reports no free blocks.
  `FBPA_ASSERT_IMP(a_empty_count, clk_i, rst_ni, rsp_valid_i && rsp_status_i == StatusEmpty, rsp_free_blocks_i == '0)

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .req_type_i         (req_i.req_type),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_block_index_i  (rsp_o.block_index),
  .rsp_block_offset_i (rsp_o.block_offset),
  .rsp_free_blocks_i  (rsp_o.free_blocks),
  .rsp_all_free_i     (rsp_o.all_free)
);
